@@ rtl/json_string_unescape_macros.svh @@
// Assertion helpers for the string unescape block.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define JSU_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

    // Default depth of the result queue; must be at least 2.
    localparam int RES_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_START,   // expecting the opening quote
        PH_BODY,    // inside the string
        PH_ESC,     // after a backslash
        PH_HEXHI,   // first \u digits
        PH_WAITHI,  // high surrogate held, looking for a backslash
        PH_BSLHI,   // high surrogate held, backslash seen
        PH_HEXLO    // digits of the low half
    } t_phase;

    typedef struct packed {
        logic [31:0] code_point;
        logic        has_char;
        logic        string_end;
    } t_result;

    // What one input item produces: zero, one or two results.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step;

endpackage

`default_nettype wire

@@ rtl/json_string_unescape.sv @@
// Streaming JSON string unescaper. Each input item is one 16-bit code unit
// of a quoted source string (tlast marks the final unit of the run). The first
// unit must be a double quote; after it, plain units pass through, the eight
// simple escapes are decoded, other escaped units pass through unchanged, and
// \u takes exactly the next four units as hex digits (non-hex units read as
// zero). A high surrogate directly followed by \u joins the next four digits
// into one code point without range checks. The string ends at the closing
// quote, a NUL or the unit flagged last; every string yields exactly one result
// with tlast set (a bare end marker with tuser low and zero data if nothing else
// is emitted at that point), and units after the end up to tlast produce no
// results. Rate: one item per clock in steady state; the input side accepts
// whenever the queue has room for two results. An accepted item passes the
// input register, then is decoded into the result queue. An item yields zero,
// one or two results; the result queue drains one per clock while the consumer
// is ready, so a run of items that each yield two results (a lone high
// surrogate followed by a character) is paced by the queue output port.
`default_nettype none

`include "json_string_unescape_macros.svh"

module json_string_unescape import jsu_pkg::*; #(
    parameter int RES_QUEUE_DEPTH = RES_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  wire logic        s_axis_tlast,   // last_unit
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] code_point
    output logic [0:0]       m_axis_tuser,   // [0] has_char
    output logic             m_axis_tlast    // string_end
);

    // input register
    logic        r_in_valid;
    logic [15:0] r_in_unit;
    logic        r_in_last;

    logic        w_room_two;
    logic        w_advance;
    t_step       w_step;
    t_result     w_result;

    // the registered item moves on when the queue can take both results
    assign w_advance     = r_in_valid && w_room_two;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_unit <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // decoder state and per-item decode
    jsu_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_unit    (r_in_unit),
        .i_last    (r_in_last),
        .o_step    (w_step)
    );

    // result queue, one result out per clock while the output is ready
    jsu_res_fifo #(
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_advance),
        .i_step     (w_step),
        .o_room_two (w_room_two),
        .o_valid    (m_axis_tvalid),
        .o_result   (w_result),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata    = w_result.code_point;
    assign m_axis_tuser[0] = w_result.has_char;
    assign m_axis_tlast    = w_result.string_end;

    // a result without a character is only ever the bare end marker
    `JSU_ASSERT_NOW(a_bare_end, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tlast && (m_axis_tdata == 32'd0),
        "result without character is not a clean end marker")

    // when an item yields two results, the first never closes the string
    `JSU_ASSERT_NOW(a_pair_order, i_clk, i_rst_n,
        w_advance && (w_step.count == 2'd2),
        !w_step.r0.string_end && w_step.r0.has_char,
        "first of two results carries the end flag")

    // the result queue comes out of reset empty
    `JSU_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid,
        "result valid right after reset")

endmodule

`default_nettype wire

@@ rtl/jsu_core.sv @@
`default_nettype none

module jsu_core import jsu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    input  wire logic [15:0] i_unit,
    input  wire logic        i_last,
    output t_step            o_step
);

    localparam logic [15:0] CH_NUL   = 16'h0000;
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_BSL   = 16'h005C;
    localparam logic [15:0] CH_N     = 16'h006E;
    localparam logic [15:0] CH_T     = 16'h0074;
    localparam logic [15:0] CH_R     = 16'h0072;
    localparam logic [15:0] CH_B     = 16'h0062;
    localparam logic [15:0] CH_F     = 16'h0066;
    localparam logic [15:0] CH_U     = 16'h0075;
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [31:0] SURR_HI_BASE = 32'h0000D800;
    // 0x10000 - 0xDC00: low-half bias folded into one constant
    localparam logic [31:0] SURR_BIAS = 32'h00002400;

    function automatic logic [3:0] hex_val(input logic [15:0] u);
        logic [3:0] v;
        v = 4'd0;
        if (u >= 16'h0030 && u <= 16'h0039) begin
            v = u[3:0];
        end else if ((u >= 16'h0061 && u <= 16'h0066) ||
                     (u >= 16'h0041 && u <= 16'h0046)) begin
            v = u[3:0] + 4'd9;
        end
        return v;
    endfunction

    // Left-justify a short run of hex digits (missing digits count as zero).
    function automatic logic [15:0] padded(input logic [15:0] acc, input logic [2:0] n);
        logic [15:0] v;
        case (n)
            3'd0:    v = 16'h0000;
            3'd1:    v = {acc[3:0], 12'h000};
            3'd2:    v = {acc[7:0], 8'h00};
            3'd3:    v = {acc[11:0], 4'h0};
            default: v = acc;
        endcase
        return v;
    endfunction

    t_phase      r_phase, n_phase;
    logic [15:0] r_hi, n_hi;
    logic [15:0] r_lo, n_lo;
    logic [1:0]  r_dc, n_dc;
    logic        r_fin, n_fin;

    // shared helpers
    logic        is_nul, is_bsl, is_end_char;
    logic [2:0]  dc_inc;
    logic [15:0] acc_hi_next, acc_lo_next;
    logic [2:0]  fin_n;
    logic        hex_stop, hex_finish;
    logic [15:0] hi_pad, lo_pad;
    logic        hi_keep;
    logic [31:0] hi_off, lo_full;
    logic        body_emit, body_end;
    t_phase      body_phase;

    // emission
    logic [1:0]  e_cnt;
    logic [31:0] e_cp0, e_cp1;
    logic        e_end;
    logic        step_end;

    always_comb begin
        is_nul      = (i_unit == CH_NUL);
        is_bsl      = (i_unit == CH_BSL);
        is_end_char = is_nul || (i_unit == CH_QUOTE);
        dc_inc      = {1'b0, r_dc} + 3'd1;
        acc_hi_next = {r_hi[11:0], hex_val(i_unit)};
        acc_lo_next = {r_lo[11:0], hex_val(i_unit)};
        fin_n       = is_nul ? {1'b0, r_dc} : dc_inc;
        hex_stop    = is_nul || i_last;
        hex_finish  = hex_stop || (dc_inc == 3'd4);
        hi_pad      = padded(is_nul ? r_hi : acc_hi_next, fin_n);
        lo_pad      = padded(is_nul ? r_lo : acc_lo_next, fin_n);
        hi_keep     = (fin_n == 3'd4) && !hex_stop &&
                      (hi_pad >= SURR_HI_MIN) && (hi_pad <= SURR_HI_MAX);
        hi_off      = {16'h0000, r_hi} - SURR_HI_BASE;
        // BSLHI with last joins an all-zero low half
        lo_full     = {hi_off[21:0], 10'b0} +
                      {16'h0000, (r_phase == PH_HEXLO) ? lo_pad : 16'h0000} + SURR_BIAS;
        // an ordinary unit inside the string
        body_emit   = !is_end_char && !(is_bsl && !i_last);
        body_end    = is_end_char || i_last;
        body_phase  = (is_bsl && !i_last) ? PH_ESC : PH_BODY;
    end

    // output block: what this unit emits and whether it ends the string
    always_comb begin
        e_cnt = 2'd0;
        e_cp0 = 32'd0;
        e_cp1 = 32'd0;
        e_end = 1'b0;
        unique case (r_phase)
            PH_BODY: begin
                e_cnt = {1'b0, body_emit};
                e_cp0 = {16'h0000, i_unit};
                e_end = body_end;
            end
            PH_ESC: begin
                e_cnt = 2'd1;
                unique case (i_unit)
                    CH_NUL: begin
                        e_cp0 = {16'h0000, CH_BSL};
                        e_end = 1'b1;
                    end
                    CH_N:    e_cp0 = 32'd10;
                    CH_T:    e_cp0 = 32'd9;
                    CH_R:    e_cp0 = 32'd13;
                    CH_B:    e_cp0 = 32'd8;
                    CH_F:    e_cp0 = 32'd12;
                    CH_U:    e_cnt = {1'b0, i_last};
                    default: e_cp0 = {16'h0000, i_unit};
                endcase
            end
            PH_HEXHI: begin
                if (hex_finish && !hi_keep) begin
                    e_cnt = 2'd1;
                    e_cp0 = {16'h0000, hi_pad};
                end
                e_end = hex_stop;
            end
            PH_WAITHI: begin
                if (is_bsl) begin
                    e_end = i_last;
                end else begin
                    e_cnt = body_emit ? 2'd2 : 2'd1;
                    e_cp0 = {16'h0000, r_hi};
                    e_cp1 = {16'h0000, i_unit};
                    e_end = body_end;
                end
            end
            PH_BSLHI: begin
                if (i_unit == CH_U) begin
                    e_cnt = {1'b0, i_last};
                    e_cp0 = lo_full;
                end else begin
                    e_cnt = {1'b0, body_emit};
                    e_cp0 = {16'h0000, i_unit};
                    e_end = body_end;
                end
            end
            PH_HEXLO: begin
                if (hex_finish) begin
                    e_cnt = 2'd1;
                    e_cp0 = lo_full;
                end
                e_end = hex_stop;
            end
            default: begin
                e_end = (i_unit != CH_QUOTE);
            end
        endcase
        if (r_fin) begin
            e_cnt = 2'd0;
            e_end = 1'b0;
        end
    end

    assign step_end = !r_fin && (e_end || i_last);

    always_comb begin
        o_step.count = e_cnt;
        o_step.r0    = '{code_point: e_cp0, has_char: 1'b1,
                         string_end: step_end && (e_cnt == 2'd1)};
        o_step.r1    = '{code_point: e_cp1, has_char: 1'b1,
                         string_end: step_end};
        if (step_end && (e_cnt == 2'd0)) begin
            o_step.count = 2'd1;
            o_step.r0    = '{code_point: 32'd0, has_char: 1'b0, string_end: 1'b1};
        end
    end

    // next-state block
    always_comb begin
        n_phase = r_phase;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_dc    = r_dc;
        n_fin   = r_fin;
        if (r_fin) begin
            if (i_last) begin
                n_fin   = 1'b0;
                n_phase = PH_START;
            end
        end else begin
            unique case (r_phase)
                PH_BODY: n_phase = body_phase;
                PH_ESC: begin
                    n_phase = PH_BODY;
                    if (i_unit == CH_U) begin
                        n_hi    = 16'h0000;
                        n_dc    = 2'd0;
                        n_phase = PH_HEXHI;
                    end
                end
                PH_HEXHI: begin
                    if (!is_nul) begin
                        n_hi = acc_hi_next;
                    end
                    if (hex_finish) begin
                        n_dc    = 2'd0;
                        n_phase = hi_keep ? PH_WAITHI : PH_BODY;
                    end else begin
                        n_dc = dc_inc[1:0];
                    end
                end
                PH_WAITHI: n_phase = is_bsl ? PH_BSLHI : body_phase;
                PH_BSLHI: begin
                    if (i_unit == CH_U) begin
                        n_lo    = 16'h0000;
                        n_dc    = 2'd0;
                        n_phase = PH_HEXLO;
                    end else begin
                        n_phase = body_phase;
                    end
                end
                PH_HEXLO: begin
                    if (!is_nul) begin
                        n_lo = acc_lo_next;
                    end
                    if (hex_finish) begin
                        n_dc    = 2'd0;
                        n_phase = PH_BODY;
                    end else begin
                        n_dc = dc_inc[1:0];
                    end
                end
                default: n_phase = PH_BODY;
            endcase
            if (step_end) begin
                n_phase = PH_START;
                n_dc    = 2'd0;
                n_fin   = !i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_hi    <= 16'h0000;
            r_lo    <= 16'h0000;
            r_dc    <= 2'd0;
            r_fin   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_dc    <= n_dc;
            r_fin   <= n_fin;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_res_fifo.sv @@
`default_nettype none

module jsu_res_fifo import jsu_pkg::*; #(
    parameter int DEPTH = RES_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_step i_step,
    output logic       o_room_two,
    output logic       o_valid,
    output t_result    o_result,
    input  wire logic  i_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] wr_ptr1;
    logic [1:0]    push_cnt;
    logic          pop;

    assign wr_ptr1    = ptr_inc(r_wr_ptr);
    assign push_cnt   = i_push ? i_step.count : 2'd0;
    assign pop        = o_valid && i_ready;
    assign o_valid    = (r_count != '0);
    assign o_result   = r_mem[r_rd_ptr];
    assign o_room_two = (r_count <= ROOM_LIMIT);

    always_comb begin
        case (push_cnt)
            2'd0:    n_wr_ptr = r_wr_ptr;
            2'd1:    n_wr_ptr = wr_ptr1;
            default: n_wr_ptr = ptr_inc(wr_ptr1);
        endcase
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_step.r0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_step.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire
